[rtl/mrl_pkg.sv]
// shared types and constants for the masked route lookup block
// no dependencies; used by masked_route_lookup

package mrl_pkg;

  // request codes
  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  // field widths
  localparam int CFG_W    = 6;
  localparam int INDEX_W  = 5;
  localparam int ADDR_W   = 16;
  localparam int METRIC_W = 8;
  localparam int IFACE_W  = 8;
  localparam int ENTRY_W  = 64;

  // width used to compare a write index against the table depth (depth up to 511)
  localparam int DEPTH_CMP_W = 9;

  // special values
  localparam logic [ADDR_W-1:0]  GATEWAY_LOCAL = 16'h0000;
  localparam logic [IFACE_W-1:0] MISS_IFACE    = 8'hFF;
  localparam logic [IFACE_W-1:0] WRITE_IFACE   = 8'h00;

  // packed route entry, lsb first: dest, mask, gateway, metric, iface
  typedef struct packed {
    logic [IFACE_W-1:0]  iface;
    logic [METRIC_W-1:0] metric;
    logic [ADDR_W-1:0]   gateway;
    logic [ADDR_W-1:0]   mask;
    logic [ADDR_W-1:0]   dest;
  } entry_t;

endpackage

[rtl/mrl_ram.sv]
// generic simple dual port ram: one write port, one read port, registered read
// no dependencies

module mrl_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/masked_route_lookup.sv]
// route table with masked-match lookup, table held in one synchronous ram
// depends on mrl_pkg and mrl_ram
//
// usage:
//   requests arrive on the input channel (in_valid / in_stall), one transfer
//   per request. req_type selects a table write or a destination lookup.
//   every request gives exactly one result transfer on the output channel
//   (out_valid / out_stall): writes report zeros, lookups report the chosen
//   interface, match flag and local-route flag (miss: interface 255).
//   the user must set entries_in_use through cfg_write_en / cfg_write_data
//   only while idle; the block itself does not enforce this.
//   a write goes from idle straight to emit; a lookup scans n entries
//   (n = min(entries_in_use, TABLE_DEPTH)), stopping early at a local route.
//   the scan reads one ram entry per cycle through the single read port,
//   which sets the lookup time; emit then waits for a free output register.
//   one request is in flight at a time, so reads never overlap a write.
// reset and stall:
//   rst (synchronous) returns to idle, drops out_valid and clears
//   entries_in_use; table contents are not cleared. a stalled result holds in
//   the output register while the next request is already taken and worked.

module masked_route_lookup #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          cfg_write_en,
  input  logic [mrl_pkg::CFG_W-1:0]     cfg_write_data,
  // request channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          req_type,
  input  logic [mrl_pkg::INDEX_W-1:0]   entry_index,
  input  logic [mrl_pkg::ADDR_W-1:0]    entry_dest,
  input  logic [mrl_pkg::ADDR_W-1:0]    entry_mask,
  input  logic [mrl_pkg::ADDR_W-1:0]    entry_gateway,
  input  logic [mrl_pkg::METRIC_W-1:0]  entry_metric,
  input  logic [mrl_pkg::IFACE_W-1:0]   entry_iface,
  input  logic [mrl_pkg::ADDR_W-1:0]    lookup_addr,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          route_hit,
  output logic [mrl_pkg::IFACE_W-1:0]   out_iface,
  output logic                          local_route
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW    = $clog2(TABLE_DEPTH + 1);
  localparam int LW    = (CW > mrl_pkg::CFG_W) ? CW : mrl_pkg::CFG_W;
  localparam int WXW   = (IDX_W > mrl_pkg::INDEX_W) ? IDX_W : mrl_pkg::INDEX_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]                     state;
  logic [mrl_pkg::CFG_W-1:0]      entries_in_use;

  // lookup working registers
  logic [mrl_pkg::ADDR_W-1:0]     lk_addr;
  logic [CW-1:0]                  lim;
  logic [CW-1:0]                  cur;
  logic                           found;
  logic [mrl_pkg::METRIC_W-1:0]   best_metric;
  logic [mrl_pkg::IFACE_W-1:0]    best_iface;

  // pending result
  logic                           res_found;
  logic [mrl_pkg::IFACE_W-1:0]    res_iface;
  logic                           res_local;

  logic                           in_xfer;
  logic                           out_free;
  logic                           tbl_wr_en;
  logic [WXW-1:0]                 wr_idx_ext;
  logic [IDX_W-1:0]               rd_addr;
  logic [mrl_pkg::ENTRY_W-1:0]    rd_data;
  mrl_pkg::entry_t                wr_ent;
  mrl_pkg::entry_t                ent;

  logic [LW-1:0]                  cfg_ext;
  logic [LW-1:0]                  lim_full;
  logic [CW-1:0]                  lim_in;
  logic [CW-1:0]                  cur_next;
  logic                           scan_last;
  logic                           hit;
  logic                           hit_local;
  logic                           hit_better;

  // handshakes
  assign in_stall = (state != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // scan length, clamped to the table depth
  assign cfg_ext  = LW'(entries_in_use);
  assign lim_full = (cfg_ext > LW'(TABLE_DEPTH)) ? LW'(TABLE_DEPTH) : cfg_ext;
  assign lim_in   = lim_full[CW-1:0];

  // table write, indexes beyond the depth are dropped
  assign wr_idx_ext = WXW'(entry_index);
  assign tbl_wr_en  = in_xfer && (req_type == mrl_pkg::REQ_WRITE) &&
                      (mrl_pkg::DEPTH_CMP_W'(entry_index) <
                       mrl_pkg::DEPTH_CMP_W'(TABLE_DEPTH));
  assign wr_ent = '{iface:   entry_iface,
                    metric:  entry_metric,
                    gateway: entry_gateway,
                    mask:    entry_mask,
                    dest:    entry_dest};

  // scan step on the entry currently on the read port
  assign cur_next   = cur + CW'(1);
  assign scan_last  = (cur_next == lim);
  assign ent        = mrl_pkg::entry_t'(rd_data);
  assign hit        = ((lk_addr ^ ent.dest) & ent.mask) == '0;
  assign hit_local  = hit && (ent.gateway == mrl_pkg::GATEWAY_LOCAL);
  assign hit_better = hit && (!found || (ent.metric < best_metric));

  // read address: next entry while scanning, entry 0 otherwise
  assign rd_addr = (state == S_SCAN && !scan_last) ? cur_next[IDX_W-1:0] : '0;

  mrl_ram #(
    .WIDTH (mrl_pkg::ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (tbl_wr_en),
    .wr_addr (wr_idx_ext[IDX_W-1:0]),
    .wr_data (wr_ent),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      out_valid      <= 1'b0;
      entries_in_use <= '0;
    end else begin
      if (cfg_write_en) begin
        entries_in_use <= cfg_write_data;
      end
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            if (req_type == mrl_pkg::REQ_LOOKUP && lim_in != '0) begin
              state <= S_SCAN;
            end else begin
              state <= S_EMIT;
            end
          end
        end
        S_SCAN: begin
          if (hit_local || scan_last) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (state == S_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // working and result payload
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_xfer) begin
          lk_addr <= lookup_addr;
          lim     <= lim_in;
          cur     <= '0;
          found   <= 1'b0;
          if (req_type == mrl_pkg::REQ_WRITE) begin
            res_found <= 1'b0;
            res_iface <= mrl_pkg::WRITE_IFACE;
            res_local <= 1'b0;
          end else begin
            res_found <= 1'b0;
            res_iface <= mrl_pkg::MISS_IFACE;
            res_local <= 1'b0;
          end
        end
      end
      S_SCAN: begin
        cur <= cur_next;
        if (hit) begin
          found <= 1'b1;
        end
        if (hit_better) begin
          best_metric <= ent.metric;
          best_iface  <= ent.iface;
        end
        // a local route ends the scan at once
        if (hit_local) begin
          res_found <= 1'b1;
          res_iface <= ent.iface;
          res_local <= 1'b1;
        end else if (scan_last) begin
          res_found <= found || hit;
          res_local <= 1'b0;
          if (hit_better) begin
            res_iface <= ent.iface;
          end else if (found) begin
            res_iface <= best_iface;
          end else begin
            res_iface <= mrl_pkg::MISS_IFACE;
          end
        end
      end
      default: begin
      end
    endcase
    if (state == S_EMIT && out_free) begin
      route_hit   <= res_found;
      out_iface   <= res_iface;
      local_route <= res_local;
    end
  end

  // scan pointer stays inside the requested range
  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (cur < lim))
    else $error("scan pointer beyond scan length");

  // one request at a time: a transfer is followed by a busy cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> in_stall)
    else $error("request taken while previous one in flight");

  // a free output register takes the pending result and the block goes idle
  a_emit: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && out_free) |=> (out_valid && state == S_IDLE))
    else $error("pending result not delivered");

  // a local route is always a match
  a_local_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(local_route && !route_hit))
    else $error("local route flagged without a match");

endmodule

[dv/tb_masked_route_lookup.sv]
// testbench for masked_route_lookup: table writes and masked-match lookups
// checked against a cycle-free route table tracker; depends on mrl_pkg and the rtl
`timescale 1ns / 1ps

module tb_masked_route_lookup;

  localparam int DEPTH        = 32;
  localparam int DRAIN_CYCLES = DEPTH + 8;
  localparam int LONG_HOLD    = 300;
  localparam int IDLE_LIMIT   = 4000;
  localparam int PHASE_ITEMS  = 55;

  typedef struct packed {
    logic                        req_type;
    logic [mrl_pkg::INDEX_W-1:0] index;
    mrl_pkg::entry_t             entry;
    logic [mrl_pkg::ADDR_W-1:0]  addr;
  } route_req_t;

  typedef struct packed {
    logic                        hit;
    logic [mrl_pkg::IFACE_W-1:0] iface;
    logic                        local_hit;
  } route_result_t;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_e;

  // keeps its own copy of the route table and the lookup count
  class route_checker;
    mrl_pkg::entry_t route_tbl[DEPTH];
    int unsigned     entries_in_use;
    route_result_t   expected_routes[$];
    int unsigned     errors;
    int unsigned     results_seen;
    int unsigned     n_writes, n_lookups, n_local, n_remote, n_miss;

    function new();
      entries_in_use = 0;
      errors = 0;
      results_seen = 0;
      n_writes = 0;
      n_lookups = 0;
      n_local = 0;
      n_remote = 0;
      n_miss = 0;
    endfunction

    task report(string msg);
      $display("ERROR: %s", msg);
      errors++;
    endtask

    function void set_entries_in_use(int unsigned v);
      entries_in_use = v;
    endfunction

    function int unsigned pending();
      return expected_routes.size();
    endfunction

    // applies a write or works out the route chosen for a lookup
    function route_result_t route_decision(route_req_t r);
      route_result_t res;
      mrl_pkg::entry_t e;
      int unsigned scan;
      logic [mrl_pkg::METRIC_W-1:0] best_metric;
      res = '0;
      best_metric = '0;
      if (r.req_type == mrl_pkg::REQ_WRITE) begin
        if (r.index < DEPTH) route_tbl[r.index] = r.entry;
        return res;
      end
      scan = (entries_in_use > DEPTH) ? DEPTH : entries_in_use;
      for (int i = 0; i < scan; i++) begin
        e = route_tbl[i];
        if ((r.addr & e.mask) != (e.dest & e.mask)) continue;
        // a local network wins at once
        if (e.gateway == mrl_pkg::GATEWAY_LOCAL) begin
          res.hit = 1'b1;
          res.local_hit = 1'b1;
          res.iface = e.iface;
          break;
        end
        // strictly lower metric only, so the earliest wins a tie
        if (!res.hit || e.metric < best_metric) begin
          best_metric = e.metric;
          res.iface = e.iface;
        end
        res.hit = 1'b1;
      end
      if (!res.hit) res.iface = mrl_pkg::MISS_IFACE;
      return res;
    endfunction

    function void note_request(route_req_t r);
      route_result_t res;
      res = route_decision(r);
      expected_routes.push_back(res);
      if (r.req_type == mrl_pkg::REQ_WRITE) n_writes++;
      else begin
        n_lookups++;
        if (!res.hit) n_miss++;
        else if (res.local_hit) n_local++;
        else n_remote++;
      end
    endfunction

    task check_result(logic hit, logic [mrl_pkg::IFACE_W-1:0] iface, logic local_hit);
      route_result_t exp_r;
      results_seen++;
      if (expected_routes.size() == 0) begin
        report($sformatf("result %0d arrived with none expected", results_seen));
        return;
      end
      exp_r = expected_routes.pop_front();
      if (hit !== exp_r.hit)
        report($sformatf("result %0d route_hit: expected %0d, got %0d",
                         results_seen, exp_r.hit, hit));
      if (iface !== exp_r.iface)
        report($sformatf("result %0d out_iface: expected %0d, got %0d",
                         results_seen, exp_r.iface, iface));
      if (local_hit !== exp_r.local_hit)
        report($sformatf("result %0d local_route: expected %0d, got %0d",
                         results_seen, exp_r.local_hit, local_hit));
    endtask

    task finish();
      if (expected_routes.size() != 0)
        report($sformatf("%0d results never arrived", expected_routes.size()));
    endtask
  endclass

  logic                         clk = 1'b0;
  logic                         rst;
  logic                         cfg_write_en;
  logic [mrl_pkg::CFG_W-1:0]    cfg_write_data;
  logic                         in_valid;
  logic                         in_stall;
  logic                         req_type;
  logic [mrl_pkg::INDEX_W-1:0]  entry_index;
  logic [mrl_pkg::ADDR_W-1:0]   entry_dest;
  logic [mrl_pkg::ADDR_W-1:0]   entry_mask;
  logic [mrl_pkg::ADDR_W-1:0]   entry_gateway;
  logic [mrl_pkg::METRIC_W-1:0] entry_metric;
  logic [mrl_pkg::IFACE_W-1:0]  entry_iface;
  logic [mrl_pkg::ADDR_W-1:0]   lookup_addr;
  logic                         out_valid;
  logic                         out_stall;
  logic                         route_hit;
  logic [mrl_pkg::IFACE_W-1:0]  out_iface;
  logic                         local_route;

  route_checker chk;
  int unsigned  burst_left = 0;

  masked_route_lookup #(.TABLE_DEPTH(DEPTH)) u_top (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .req_type       (req_type),
    .entry_index    (entry_index),
    .entry_dest     (entry_dest),
    .entry_mask     (entry_mask),
    .entry_gateway  (entry_gateway),
    .entry_metric   (entry_metric),
    .entry_iface    (entry_iface),
    .lookup_addr    (lookup_addr),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .route_hit      (route_hit),
    .out_iface      (out_iface),
    .local_route    (local_route)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // random entry, masks mostly prefixes, metrics often small to force ties
  function automatic mrl_pkg::entry_t make_entry();
    mrl_pkg::entry_t e;
    int unsigned pick;
    e.dest = 16'($urandom);
    pick = $urandom_range(0, 19);
    if (pick == 0) e.mask = '0;
    else if (pick < 4) e.mask = '1;
    else if (pick < 12) e.mask = 16'hFFFF << $urandom_range(0, 8);
    else e.mask = 16'($urandom);
    e.gateway = ($urandom_range(0, 3) == 0) ? mrl_pkg::GATEWAY_LOCAL : 16'($urandom);
    e.metric  = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
    e.iface   = 8'($urandom);
    return e;
  endfunction

  // every field but the index random, including the ones the request type ignores
  function automatic route_req_t make_write(int unsigned idx);
    route_req_t r;
    r.req_type = mrl_pkg::REQ_WRITE;
    r.index    = mrl_pkg::INDEX_W'(idx);
    r.entry    = make_entry();
    r.addr     = 16'($urandom);
    return r;
  endfunction

  // lookup aimed at an entry in scan range most of the time
  function automatic route_req_t make_lookup();
    route_req_t r;
    mrl_pkg::entry_t e;
    int unsigned scan;
    r = make_write($urandom_range(0, DEPTH - 1));
    r.req_type = mrl_pkg::REQ_LOOKUP;
    scan = (chk.entries_in_use > DEPTH) ? DEPTH : chk.entries_in_use;
    if (scan > 0 && $urandom_range(0, 99) < 65) begin
      e = chk.route_tbl[$urandom_range(0, scan - 1)];
      r.addr = (e.dest & e.mask) | (r.addr & ~e.mask);
    end else if ($urandom_range(0, 9) == 0) begin
      r.addr = ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF;
    end
    return r;
  endfunction

  function automatic route_req_t wr(int unsigned idx, logic [15:0] dest, logic [15:0] mask,
                                   logic [15:0] gw, logic [7:0] metric, logic [7:0] iface);
    route_req_t r;
    r = make_write(idx);
    r.entry.dest    = dest;
    r.entry.mask    = mask;
    r.entry.gateway = gw;
    r.entry.metric  = metric;
    r.entry.iface   = iface;
    return r;
  endfunction

  function automatic route_req_t lk(logic [15:0] addr);
    route_req_t r;
    r = make_write($urandom_range(0, DEPTH - 1));
    r.req_type = mrl_pkg::REQ_LOOKUP;
    r.addr = addr;
    return r;
  endfunction

  // offer one request and hold it until the transfer
  task automatic send(input route_req_t r);
    int unsigned gap;
    in_valid      <= 1'b1;
    req_type      <= r.req_type;
    entry_index   <= r.index;
    entry_dest    <= r.entry.dest;
    entry_mask    <= r.entry.mask;
    entry_gateway <= r.entry.gateway;
    entry_metric  <= r.entry.metric;
    entry_iface   <= r.entry.iface;
    lookup_addr   <= r.addr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    chk.note_request(r);
    // bursts of random length with random gaps, some with no gap at all
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // stop offering until every result is back, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    while (chk.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input int unsigned v);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= mrl_pkg::CFG_W'(v);
    @(posedge clk);
    cfg_write_en   <= 1'b0;
    chk.set_entries_in_use(v);
  endtask

  // result side: check each transfer, stall on a changing pattern
  stall_mode_e stall_mode = STALL_NONE;
  int unsigned mode_left = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 0;
  int unsigned cycle_no = 0;

  always @(posedge clk) begin
    cycle_no++;
    if (!rst && out_valid && !out_stall)
      chk.check_result(route_hit, out_iface, local_route);
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (!hold_done && chk.results_seen >= 200) begin
      // one long hold so the block backs up into its input
      hold_done = 1;
      hold_left = LONG_HOLD - 1;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_e'($urandom_range(0, 3));
        mode_left  = $urandom_range(20, 120);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:     out_stall <= ((cycle_no % 7) < 3);
      endcase
    end
  end

  // watchdog on cycles with no transfer on either channel
  int unsigned idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // stimulus
  int unsigned fill_order[DEPTH - 8];
  int unsigned cfg_plan[8] = '{32, 1, 63, 0, 33, 17, 2, 31};

  initial begin
    int unsigned j, tmp, v;
    chk = new();
    rst            <= 1'b1;
    cfg_write_en   <= 1'b0;
    cfg_write_data <= '0;
    in_valid       <= 1'b0;
    req_type       <= mrl_pkg::REQ_WRITE;
    entry_index    <= '0;
    entry_dest     <= '0;
    entry_mask     <= '0;
    entry_gateway  <= '0;
    entry_metric   <= '0;
    entry_iface    <= '0;
    lookup_addr    <= '0;
    out_stall      <= 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // count still at its reset value of zero: every lookup misses
    send(lk(16'h0000));
    send(lk(16'hFFFF));
    // hand-made entries covering ties, local wins and the extremes
    send(wr(0, 16'h1200, 16'hFF00, 16'h0A01, 8'd50,  8'd1));
    send(wr(1, 16'h1234, 16'hFFFF, 16'h0A02, 8'd20,  8'd2));
    send(wr(2, 16'h1200, 16'hFF00, 16'h0A03, 8'd20,  8'd3));
    send(wr(3, 16'h5600, 16'hFF00, 16'h0000, 8'd255, 8'd4));
    send(wr(4, 16'h5678, 16'hFFFF, 16'h0000, 8'd0,   8'd5));
    send(wr(5, 16'h0000, 16'h0000, 16'hFFFF, 8'd255, 8'd6));
    send(wr(6, 16'hFFFF, 16'hFFFF, 16'h0000, 8'd0,   8'd255));
    send(wr(7, 16'hABCD, 16'hF0F0, 16'h0001, 8'd0,   8'd0));

    // fill the rest of the table in shuffled order, lookups in between
    for (int i = 0; i < DEPTH - 8; i++) fill_order[i] = i + 8;
    for (int i = DEPTH - 9; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = fill_order[i];
      fill_order[i] = fill_order[j];
      fill_order[j] = tmp;
    end
    for (int i = 0; i < DEPTH - 8; i++) begin
      send(make_write(fill_order[i]));
      if ($urandom_range(0, 2) == 0) send(make_lookup());
    end
    drain();

    // first five entries: tie on metric, earliest local, miss
    write_cfg(5);
    send(lk(16'h1234));
    send(lk(16'h12FF));
    send(lk(16'h5678));
    send(lk(16'h9999));
    send(lk(16'h0000));
    drain();

    // default route in range: remote only, local at 255, metric zero
    write_cfg(8);
    send(lk(16'h9999));
    send(lk(16'hFFFF));
    send(lk(16'hA0C0));
    send(lk(16'h1234));
    drain();

    // random phases over a spread of lookup counts
    for (int p = 0; p < 12; p++) begin
      v = (p < 8) ? cfg_plan[p] : $urandom_range(0, 63);
      write_cfg(v);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 99) < 30) send(make_write($urandom_range(0, DEPTH - 1)));
        else send(make_lookup());
      end
      drain();
    end

    chk.finish();
    $display("covered %0d table writes and %0d lookups over 14 lookup-count settings",
             chk.n_writes, chk.n_lookups);
    $display("lookups gave %0d local hits, %0d remote hits and %0d misses",
             chk.n_local, chk.n_remote, chk.n_miss);
    if (chk.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
